// ===== src/assert_macros.svh =====
// assertion helpers, empty under synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, held off during reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication, held off during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== src/aeskx_pkg.sv =====
package aeskx_pkg;

  // schedule dimensions
  localparam int WordCount = 44;
  localparam int RoundCount = WordCount / 4;
  localparam logic [3:0] LAST_ROUND = 4'(RoundCount - 1);

  // one input item: the cipher key
  typedef struct packed {
    logic [63:0] key_high;
    logic [63:0] key_low;
  } key_item_t;

  // one result item: a round key
  typedef struct packed {
    logic [3:0]  round_index;
    logic [63:0] round_key_high;
    logic [63:0] round_key_low;
    logic        last_round;
  } round_item_t;

  // controller states
  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic step;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last;
  } dp_status_t;

  // aes forward s-box
  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // round constant applied when building the key after round r
  function automatic logic [7:0] rcon(input logic [3:0] r);
    logic [7:0] c;
    unique case (r)
      4'd0:    c = 8'h01;
      4'd1:    c = 8'h02;
      4'd2:    c = 8'h04;
      4'd3:    c = 8'h08;
      4'd4:    c = 8'h10;
      4'd5:    c = 8'h20;
      4'd6:    c = 8'h40;
      4'd7:    c = 8'h80;
      4'd8:    c = 8'h1b;
      4'd9:    c = 8'h36;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== src/aes128_key_expansion.sv =====
// channel | direction | payload      | handshake
// in      | input     | key_item_t   | in_valid / in_ready
// out     | output    | round_item_t | out_valid / out_ready
//
// one key yields 11 round keys, one per cycle when out_ready stays high
// the single round-expansion unit (four s-box lookups and the word xor chain)
// sets the rate; keys run back to back, the next loading as the last round key leaves
// a stall on out_ready holds the current round key; the unit waits with it
// synchronous reset returns the controller to idle with in_ready high
`include "assert_macros.svh"

module aes128_key_expansion
  import aeskx_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  key_item_t   in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output round_item_t out_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencing
  aeskx_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // round key expansion
  aeskx_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .key       (in_data),
    .status    (status),
    .round_out (out_data)
  );

  // checks
  `ASSERT_IMPLIES(a_ready_on_last, clk, rst, out_valid && out_ready && out_data.last_round, in_ready)
  `ASSERT_NEXT(a_load_starts_round0, clk, rst, in_valid && in_ready, out_valid && out_data.round_index == 4'd0)
  `ASSERT_NEXT(a_round_advances, clk, rst, out_valid && out_ready && !out_data.last_round, out_valid && out_data.round_index == $past(out_data.round_index) + 4'd1)

endmodule

// ===== src/aeskx_ctrl.sv =====
module aeskx_ctrl
  import aeskx_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t state;
  state_t state_next;
  logic   out_xfer;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    out_valid  = (state == ST_RUN);
    out_xfer   = out_valid && out_ready;
    // a new key may load on the same edge the last round key leaves
    in_ready   = (state == ST_IDLE) || (out_xfer && status.last);
    cmd.load   = in_valid && in_ready;
    cmd.step   = out_xfer && !status.last;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd.load) state_next = ST_RUN;
      end
      ST_RUN: begin
        if (out_xfer && status.last && !cmd.load) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ===== src/aeskx_datapath.sv =====
module aeskx_datapath
  import aeskx_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  dp_cmd_t     cmd,
  input  key_item_t   key,
  output dp_status_t  status,
  output round_item_t round_out
);

  logic [127:0] working_key;
  logic [3:0]   round_counter;
  logic [31:0]  w0, w1, w2, w3;
  logic [31:0]  rot;
  logic [31:0]  sub;
  logic [31:0]  n0, n1, n2, n3;

  // split current round key into words, word 0 on top
  assign w0 = working_key[127:96];
  assign w1 = working_key[95:64];
  assign w2 = working_key[63:32];
  assign w3 = working_key[31:0];

  // rotate, substitute, add round constant
  assign rot = {w3[23:0], w3[31:24]};
  assign sub = {SBOX[rot[31:24]] ^ rcon(round_counter), SBOX[rot[23:16]],
                SBOX[rot[15:8]], SBOX[rot[7:0]]};

  // chained word updates
  assign n0 = w0 ^ sub;
  assign n1 = w1 ^ n0;
  assign n2 = w2 ^ n1;
  assign n3 = w3 ^ n2;

  // round key and round counter registers
  always_ff @(posedge clk) begin
    if (rst) begin
      round_counter <= '0;
    end else if (cmd.load) begin
      round_counter <= '0;
    end else if (cmd.step) begin
      round_counter <= round_counter + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      working_key <= '0;
    end else if (cmd.load) begin
      working_key <= {key.key_high, key.key_low};
    end else if (cmd.step) begin
      working_key <= {n0, n1, n2, n3};
    end
  end

  // result and status
  assign status.last              = (round_counter == LAST_ROUND);
  assign round_out.round_index    = round_counter;
  assign round_out.round_key_high = working_key[127:64];
  assign round_out.round_key_low  = working_key[63:0];
  assign round_out.last_round     = status.last;

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import aeskx_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  key_item_t   in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  round_item_t out_data;

  key_item_t   pending_keys[$];
  round_item_t expected_rounds[$];
  logic        key_taken = 1'b0;
  int          keys_queued = 0;
  int          keys_in = 0;
  int          rounds_checked = 0;
  int          mismatches = 0;
  int          cycle_count = 0;

  aes128_key_expansion u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // clock
  initial begin
    forever #4 clk = ~clk;
  end

  // gf(2^8) multiply modulo x^8 + x^4 + x^3 + x + 1
  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    logic [7:0] x;
    acc = 8'h00;
    x = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc ^= x;
      x = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    end
    return acc;
  endfunction

  // s-box built from the field inverse (b^254) and the affine map
  function automatic logic [7:0] sub_byte(input logic [7:0] b);
    logic [7:0] inv;
    logic [7:0] sq;
    inv = 8'h01;
    sq = b;
    for (int i = 0; i < 7; i++) begin
      sq = gf_mul(sq, sq);
      inv = gf_mul(inv, sq);
    end
    return inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
         ^ {inv[3:0], inv[7:4]} ^ 8'h63;
  endfunction

  // rotate one byte left, then substitute every byte
  function automatic logic [31:0] sub_rot_word(input logic [31:0] w);
    logic [31:0] r;
    r = {w[23:0], w[31:24]};
    return {sub_byte(r[31:24]), sub_byte(r[23:16]), sub_byte(r[15:8]), sub_byte(r[7:0])};
  endfunction

  // queue the eleven round keys that one cipher key expands into
  task automatic predict_round_keys(input key_item_t k);
    logic [31:0] w0, w1, w2, w3;
    logic [7:0]  rc;
    round_item_t item;
    w0 = k.key_high[63:32];
    w1 = k.key_high[31:0];
    w2 = k.key_low[63:32];
    w3 = k.key_low[31:0];
    rc = 8'h01;
    for (int r = 0; r < 11; r++) begin
      item.round_index    = 4'(r);
      item.round_key_high = {w0, w1};
      item.round_key_low  = {w2, w3};
      item.last_round     = (r == 10);
      expected_rounds.push_back(item);
      w0 = w0 ^ sub_rot_word(w3) ^ {rc, 24'h000000};
      w1 = w1 ^ w0;
      w2 = w2 ^ w1;
      w3 = w3 ^ w2;
      rc = {rc[6:0], 1'b0} ^ (rc[7] ? 8'h1b : 8'h00);
    end
  endtask

  // random key: mostly uniform, some sparse, dense or byte-repeated
  function automatic key_item_t random_key();
    key_item_t k;
    int        pick;
    logic [7:0] b;
    pick = $urandom_range(0, 99);
    k.key_high = {$urandom, $urandom};
    k.key_low  = {$urandom, $urandom};
    if (pick >= 60 && pick < 75) begin
      k.key_high &= {$urandom, $urandom} & {$urandom, $urandom};
      k.key_low  &= {$urandom, $urandom} & {$urandom, $urandom};
    end else if (pick >= 75 && pick < 88) begin
      k.key_high |= {$urandom, $urandom} | {$urandom, $urandom};
      k.key_low  |= {$urandom, $urandom} | {$urandom, $urandom};
    end else if (pick >= 88) begin
      b = 8'($urandom);
      k.key_high = {8{b}};
      k.key_low  = {8{b}};
    end
    return k;
  endfunction

  // source side: present keys, hold until transfer, idle at random; also drives out_ready
  always @(negedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst) begin
      out_ready <= (cycle_count >= 3000 && cycle_count < 4500) ? 1'b1
                   : ($urandom_range(0, 99) >= 32);
      if (!in_valid || key_taken) begin
        if (pending_keys.size() == 0) begin
          in_valid <= 1'b0;
        end else if ((keys_queued == 25 || keys_queued == 250)
                     && expected_rounds.size() != 0) begin
          // let the block drain fully before going on
          in_valid <= 1'b0;
        end else if (!(cycle_count >= 3000 && cycle_count < 4500)
                     && $urandom_range(0, 99) < 32) begin
          in_valid <= 1'b0;
        end else begin
          in_data     <= pending_keys.pop_front();
          in_valid    <= 1'b1;
          keys_queued <= keys_queued + 1;
        end
      end
    end
  end

  // sink side: predict on key transfer, compare on round-key transfer
  always @(posedge clk) begin : monitor
    round_item_t want;
    if (rst) begin
      key_taken <= 1'b0;
    end else begin
      key_taken <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        predict_round_keys(in_data);
        keys_in++;
      end
      if (out_valid && out_ready) begin
        if (expected_rounds.size() == 0) begin
          $error("round key transfer with nothing expected: %p", out_data);
          mismatches++;
        end else begin
          want = expected_rounds.pop_front();
          rounds_checked++;
          if (out_data.round_index !== want.round_index) begin
            $error("round_index expected %0d actual %0d", want.round_index,
                   out_data.round_index);
            mismatches++;
          end
          if (out_data.round_key_high !== want.round_key_high) begin
            $error("round_key_high expected %h actual %h", want.round_key_high,
                   out_data.round_key_high);
            mismatches++;
          end
          if (out_data.round_key_low !== want.round_key_low) begin
            $error("round_key_low expected %h actual %h", want.round_key_low,
                   out_data.round_key_low);
            mismatches++;
          end
          if (out_data.last_round !== want.last_round) begin
            $error("last_round expected %0d actual %0d", want.last_round,
                   out_data.last_round);
            mismatches++;
          end
        end
      end
    end
  end

  // stimulus and end of run
  initial begin : stimulus
    key_item_t k;
    // directed keys: extremes, the standard example key, patterns
    pending_keys.push_back('{key_high: 64'h0, key_low: 64'h0});
    pending_keys.push_back('{key_high: '1, key_low: '1});
    pending_keys.push_back('{key_high: 64'h2b7e151628aed2a6, key_low: 64'habf7158809cf4f3c});
    pending_keys.push_back('{key_high: 64'h0001020304050607, key_low: 64'h08090a0b0c0d0e0f});
    pending_keys.push_back('{key_high: 64'h5555555555555555, key_low: 64'haaaaaaaaaaaaaaaa});
    pending_keys.push_back('{key_high: 64'haaaaaaaaaaaaaaaa, key_low: 64'h5555555555555555});
    pending_keys.push_back('{key_high: '1, key_low: 64'h0});
    pending_keys.push_back('{key_high: 64'h0, key_low: '1});
    pending_keys.push_back('{key_high: 64'h8000000000000000, key_low: 64'h0});
    pending_keys.push_back('{key_high: 64'h0, key_low: 64'h0000000000000001});
    pending_keys.push_back('{key_high: 64'h0, key_low: 64'h00000000ffffffff});
    pending_keys.push_back('{key_high: 64'h0, key_low: 64'hffffffff00000000});
    pending_keys.push_back('{key_high: 64'h0123456789abcdef, key_low: 64'hfedcba9876543210});
    for (int i = 0; i < 8; i++) begin
      k.key_high = 64'h1 << (i * 9);
      k.key_low  = ~(64'h1 << (i * 7 + 3));
      pending_keys.push_back(k);
    end
    // random keys
    for (int i = 0; i < 480; i++) begin
      pending_keys.push_back(random_key());
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_keys.size() != 0 || in_valid) @(posedge clk);
    while (expected_rounds.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);

    if (expected_rounds.size() != 0) begin
      $error("%0d round keys never arrived", expected_rounds.size());
      mismatches++;
    end
    $display("expanded %0d keys, %0d round keys compared against the schedule",
             keys_in, rounds_checked);
    $display("random stalls on both sides, one stall-free stretch, two full drains");
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
